[hw/rtl/tlpc_pkg.sv]
// Shared types and constants of the traffic light pedestrian controller.
package tlpc_pkg;

  localparam int unsigned TimerBits   = 16;
  localparam int unsigned DurBits     = 16;
  localparam int unsigned RepBits     = 4;
  localparam int unsigned PhaseBits   = 3;
  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CfgDataBits = 16;
  localparam int unsigned CmpBits     = (TimerBits > DurBits) ? TimerBits : DurBits;

  localparam logic [DurBits-1:0] RedTicksRst    = DurBits'(5000);
  localparam logic [DurBits-1:0] YellowTicksRst = DurBits'(2000);
  localparam logic [DurBits-1:0] GreenTicksRst  = DurBits'(5000);
  localparam logic [DurBits-1:0] BlinkHalfRst   = DurBits'(500);
  localparam logic [RepBits-1:0] BlinkRepRst    = RepBits'(5);
  localparam logic [DurBits-1:0] WalkTicksRst   = DurBits'(5000);

  typedef enum logic [CfgIdxBits-1:0] {
    RegRedTicks    = 3'd0,
    RegYellowTicks = 3'd1,
    RegGreenTicks  = 3'd2,
    RegBlinkHalf   = 3'd3,
    RegBlinkRep    = 3'd4,
    RegWalkTicks   = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [DurBits-1:0] red_ticks;
    logic [DurBits-1:0] yellow_ticks;
    logic [DurBits-1:0] green_ticks;
    logic [DurBits-1:0] blink_half_ticks;
    logic [RepBits-1:0] blink_repeats;
    logic [DurBits-1:0] walk_green_ticks;
  } cfg_t;

endpackage

[hw/rtl/tlpc_if.sv]
// Tick and lamp channel interfaces of the traffic light pedestrian controller.
interface tlpc_tick_if;
  logic valid;
  logic ready;
  logic button_down;

  modport source (output valid, output button_down, input ready);
  modport sink   (input valid, input button_down, output ready);
endinterface

interface tlpc_lamp_if;
  logic       valid;
  logic       ready;
  logic       red_on;
  logic       yellow_on;
  logic       green_on;
  logic       request_waiting;
  logic [2:0] phase_code;

  modport source (output valid, output red_on, output yellow_on, output green_on,
                  output request_waiting, output phase_code, input ready);
  modport sink   (input valid, input red_on, input yellow_on, input green_on,
                  input request_waiting, input phase_code, output ready);
endinterface

[hw/rtl/tlpc_cfg.sv]
// Configuration register file with zero-duration and zero-repeat clamping.
module tlpc_cfg
  import tlpc_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [CfgDataBits-1:0] cfg_data_i,
  output cfg_t                   cfg_o
);

  cfg_t               cfg_q;
  logic [DurBits-1:0] dur_w;
  logic [RepBits-1:0] rep_w;

  // clamp zero to one
  assign dur_w = (cfg_data_i[DurBits-1:0] == '0) ? DurBits'(1) : cfg_data_i[DurBits-1:0];
  assign rep_w = (cfg_data_i[RepBits-1:0] == '0) ? RepBits'(1) : cfg_data_i[RepBits-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.red_ticks        <= RedTicksRst;
      cfg_q.yellow_ticks     <= YellowTicksRst;
      cfg_q.green_ticks      <= GreenTicksRst;
      cfg_q.blink_half_ticks <= BlinkHalfRst;
      cfg_q.blink_repeats    <= BlinkRepRst;
      cfg_q.walk_green_ticks <= WalkTicksRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegRedTicks:    cfg_q.red_ticks        <= dur_w;
        RegYellowTicks: cfg_q.yellow_ticks     <= dur_w;
        RegGreenTicks:  cfg_q.green_ticks      <= dur_w;
        RegBlinkHalf:   cfg_q.blink_half_ticks <= dur_w;
        RegBlinkRep:    cfg_q.blink_repeats    <= rep_w;
        RegWalkTicks:   cfg_q.walk_green_ticks <= dur_w;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

[hw/rtl/traffic_light_pedestrian_controller.sv]
// The lamp result of a transferred tick is registered in the output register.
// Throughput: one tick per cycle while the lamp output is not stalled; the phase step is one compare and increment.
// The output register holds a result under backpressure while the next tick
// is taken as soon as that register is freed by a transfer in the same cycle.
// Reset: asynchronous, active low; red phase, counters and request cleared,
// configuration registers back to their default durations.
module traffic_light_pedestrian_controller
  import tlpc_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [CfgDataBits-1:0] cfg_data_i,
  tlpc_tick_if.sink              tick_i,
  tlpc_lamp_if.source            lamp_o
);

  typedef enum logic [PhaseBits-1:0] {
    PhRed      = 3'd0,
    PhYellow   = 3'd1,
    PhGreen    = 3'd2,
    PhBlinkOn  = 3'd3,
    PhBlinkOff = 3'd4,
    PhWalk     = 3'd5,
    PhWait     = 3'd6
  } phase_e;

  localparam logic [TimerBits-1:0] TimerMax = {TimerBits{1'b1}};

  cfg_t                 cfg;
  phase_e               phase_q, phase_d;
  logic [TimerBits-1:0] elapsed_q, elapsed_d, elapsed_inc;
  logic [RepBits-1:0]   blinks_q, blinks_d, blinks_inc;
  logic                 req_q, req_d;
  logic [DurBits-1:0]   dur;
  logic                 tdone;
  logic                 accept;
  logic                 out_valid_q;
  logic                 red_q, yellow_q, green_q, reqw_q;
  logic [PhaseBits-1:0] phase_code_q;

  tlpc_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  assign tick_i.ready = !out_valid_q || lamp_o.ready;
  assign accept       = tick_i.valid && tick_i.ready;

  assign elapsed_inc = (elapsed_q != TimerMax) ? elapsed_q + 1'b1 : elapsed_q;
  assign blinks_inc  = blinks_q + 1'b1;
  assign tdone       = (CmpBits'(elapsed_inc) >= CmpBits'(dur)) || (elapsed_inc == TimerMax);

  always_comb begin
    dur       = cfg.red_ticks;
    phase_d   = phase_q;
    elapsed_d = elapsed_inc;
    blinks_d  = blinks_q;
    req_d     = req_q;
    if ((phase_q == PhRed || phase_q == PhYellow || phase_q == PhGreen) && tick_i.button_down) begin
      req_d = 1'b1;
    end
    unique case (phase_q)
      PhRed: begin
        dur = cfg.red_ticks;
        if (tdone) phase_d = PhYellow;
      end
      PhYellow: begin
        dur = cfg.yellow_ticks;
        if (tdone) phase_d = PhGreen;
      end
      PhGreen: begin
        dur = cfg.green_ticks;
        if (tdone) begin
          if (req_d) begin
            req_d    = 1'b0;
            blinks_d = '0;
            phase_d  = PhBlinkOn;
          end else begin
            phase_d = PhRed;
          end
        end
      end
      PhBlinkOn: begin
        dur = cfg.blink_half_ticks;
        if (tdone) phase_d = PhBlinkOff;
      end
      PhBlinkOff: begin
        dur = cfg.blink_half_ticks;
        if (tdone) begin
          blinks_d = blinks_inc;
          if (blinks_inc >= cfg.blink_repeats || blinks_inc == '0) phase_d = PhWalk;
          else phase_d = PhBlinkOn;
        end
      end
      PhWalk: begin
        dur = cfg.walk_green_ticks;
        if (tdone) phase_d = PhWait;
      end
      PhWait: begin
        elapsed_d = elapsed_q;
        if (!tick_i.button_down) begin
          phase_d   = PhRed;
          elapsed_d = '0;
        end
      end
      default: begin
        phase_d   = PhRed;
        elapsed_d = '0;
      end
    endcase
    if (tdone && phase_q != PhWait) elapsed_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhRed;
      elapsed_q   <= '0;
      blinks_q    <= '0;
      req_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        phase_q     <= phase_d;
        elapsed_q   <= elapsed_d;
        blinks_q    <= blinks_d;
        req_q       <= req_d;
        out_valid_q <= 1'b1;
      end else if (lamp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      red_q        <= (phase_d == PhRed || phase_d == PhBlinkOn || phase_d == PhBlinkOff);
      yellow_q     <= (phase_d == PhYellow || phase_d == PhBlinkOn);
      green_q      <= (phase_d == PhGreen || phase_d == PhWalk);
      reqw_q       <= req_d;
      phase_code_q <= phase_d;
    end
  end

  assign lamp_o.valid           = out_valid_q;
  assign lamp_o.red_on          = red_q;
  assign lamp_o.yellow_on       = yellow_q;
  assign lamp_o.green_on        = green_q;
  assign lamp_o.request_waiting = reqw_q;
  assign lamp_o.phase_code      = phase_code_q;

  a_no_req_in_crossing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhBlinkOn || phase_q == PhBlinkOff || phase_q == PhWalk || phase_q == PhWait)
      |-> !req_q)
    else $error("request latched during crossing");

  a_blinks_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhBlinkOn || phase_q == PhBlinkOff) |-> (blinks_q != '1))
    else $error("blink count past repeats");

  a_wait_timer_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhWait) |-> (elapsed_q == '0))
    else $error("timer running in wait release");

  a_result_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (out_valid_q && phase_code_q == phase_q && reqw_q == req_q))
    else $error("result does not match state after transfer");

endmodule

[tb/sv/testbench.sv]
// Testbench for the traffic light pedestrian controller: predicts lamp states per tick.
`timescale 1ns / 1ps

module testbench;
  import tlpc_pkg::*;

  typedef enum logic [PhaseBits-1:0] {
    PhRed, PhYellow, PhGreen, PhBlinkOn, PhBlinkOff, PhWalk, PhWait
  } phase_e;

  typedef struct packed {
    logic   red;
    logic   yellow;
    logic   green;
    logic   waiting;
    phase_e phase;
  } lamp_t;

  localparam logic [CfgIdxBits-1:0] RegSpareLo = 3'd6;
  localparam logic [CfgIdxBits-1:0] RegSpareHi = 3'd7;
  localparam logic [TimerBits-1:0]  TimerMax   = '1;
  localparam int unsigned           StallLimit = 2000;
  localparam int unsigned           TotalTicks = 1450;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CfgIdxBits-1:0]  cfg_idx_i;
  logic [CfgDataBits-1:0] cfg_data_i;

  tlpc_tick_if tick_ch ();
  tlpc_lamp_if lamp_ch ();

  traffic_light_pedestrian_controller dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .tick_i     (tick_ch),
    .lamp_o     (lamp_ch)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  cfg_t                 dur_cfg;
  phase_e               phase_now;
  logic [TimerBits-1:0] elapsed;
  logic [RepBits-1:0]   blinks_done;
  logic                 request_latched;

  lamp_t       pending_lamps[$];
  int unsigned lamp_mismatches = 0;
  int unsigned ticks_sent = 0;
  int unsigned hold_off_cycles = 0;
  int unsigned stall_cycles = 0;
  bit          src_gaps = 1'b1;
  bit          snk_gaps = 1'b1;

  function automatic void reset_lamp_model();
    dur_cfg = '{red_ticks: RedTicksRst, yellow_ticks: YellowTicksRst,
                green_ticks: GreenTicksRst, blink_half_ticks: BlinkHalfRst,
                blink_repeats: BlinkRepRst, walk_green_ticks: WalkTicksRst};
    phase_now       = PhRed;
    elapsed         = '0;
    blinks_done     = '0;
    request_latched = 1'b0;
  endfunction

  function automatic logic timer_step(logic [DurBits-1:0] dur);
    logic [DurBits-1:0] limit;
    limit = (dur == '0) ? DurBits'(1) : dur;
    if (elapsed != TimerMax) elapsed++;
    if (elapsed >= limit || elapsed == TimerMax) begin
      elapsed = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void enter_phase(phase_e p);
    phase_now = p;
    elapsed   = '0;
  endfunction

  function automatic lamp_t predict_lamps(logic btn);
    lamp_t              res;
    logic [RepBits-1:0] reps;
    if (phase_now inside {PhRed, PhYellow, PhGreen} && btn) request_latched = 1'b1;
    case (phase_now)
      PhRed: if (timer_step(dur_cfg.red_ticks)) enter_phase(PhYellow);
      PhYellow: if (timer_step(dur_cfg.yellow_ticks)) enter_phase(PhGreen);
      PhGreen: begin
        if (timer_step(dur_cfg.green_ticks)) begin
          if (request_latched) begin
            request_latched = 1'b0;
            blinks_done     = '0;
            enter_phase(PhBlinkOn);
          end else begin
            enter_phase(PhRed);
          end
        end
      end
      PhBlinkOn: if (timer_step(dur_cfg.blink_half_ticks)) enter_phase(PhBlinkOff);
      PhBlinkOff: begin
        if (timer_step(dur_cfg.blink_half_ticks)) begin
          reps = (dur_cfg.blink_repeats == '0) ? RepBits'(1) : dur_cfg.blink_repeats;
          blinks_done = blinks_done + 1'b1;
          if (blinks_done >= reps || blinks_done == '0) enter_phase(PhWalk);
          else enter_phase(PhBlinkOn);
        end
      end
      PhWalk: if (timer_step(dur_cfg.walk_green_ticks)) enter_phase(PhWait);
      PhWait: if (!btn) enter_phase(PhRed);
      default: enter_phase(PhRed);
    endcase
    res = '0;
    case (phase_now)
      PhRed: res.red = 1'b1;
      PhYellow: res.yellow = 1'b1;
      PhGreen: res.green = 1'b1;
      PhBlinkOn: begin
        res.red    = 1'b1;
        res.yellow = 1'b1;
      end
      PhBlinkOff: res.red = 1'b1;
      PhWalk: res.green = 1'b1;
      default: ;
    endcase
    res.waiting = request_latched;
    res.phase   = phase_now;
    return res;
  endfunction

  task automatic send_tick(input logic btn);
    int unsigned gap;
    gap = src_gaps ? $urandom_range(0, 6) : 0;
    if (gap != 0) begin
      tick_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    tick_ch.valid       <= 1'b1;
    tick_ch.button_down <= btn;
    @(posedge clk_i);
    while (!tick_ch.ready) @(posedge clk_i);
    pending_lamps.push_back(predict_lamps(btn));
    ticks_sent++;
  endtask

  task automatic drain_lamps();
    tick_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending_lamps.size() != 0);
  endtask

  task automatic write_reg(input logic [CfgIdxBits-1:0] idx,
                           input logic [CfgDataBits-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      RegRedTicks: dur_cfg.red_ticks = data;
      RegYellowTicks: dur_cfg.yellow_ticks = data;
      RegGreenTicks: dur_cfg.green_ticks = data;
      RegBlinkHalf: dur_cfg.blink_half_ticks = data;
      RegBlinkRep: dur_cfg.blink_repeats = data[RepBits-1:0];
      RegWalkTicks: dur_cfg.walk_green_ticks = data;
      default: ;
    endcase
  endtask

  task automatic run_until_phase(input phase_e target);
    int unsigned guard = 0;
    while (phase_now != target && guard < 200) begin
      case (phase_now)
        PhRed, PhYellow, PhGreen: send_tick(1'b1);
        PhWait: send_tick(1'b0);
        default: send_tick(1'($urandom_range(0, 1)));
      endcase
      guard++;
    end
  endtask

  task automatic test_reset_state();
    logic [0:7] buttons = 8'b0100_1100;
    for (int i = 0; i < 8; i++) send_tick(buttons[i]);
  endtask

  task automatic test_zero_settings();
    logic [0:15] buttons = 16'b0001_1110_0001_0000;
    drain_lamps();
    write_reg(RegRedTicks, '0);
    write_reg(RegYellowTicks, '0);
    write_reg(RegGreenTicks, '0);
    write_reg(RegBlinkHalf, '0);
    write_reg(RegBlinkRep, '0);
    write_reg(RegWalkTicks, '0);
    write_reg(RegSpareLo, 16'h1234);
    write_reg(RegSpareHi, 16'hFFFF);
    for (int i = 0; i < 16; i++) send_tick(buttons[i]);
  endtask

  task automatic test_full_scale();
    phase_e   stops[6];
    cfg_reg_e regs[6];
    stops = '{PhRed, PhYellow, PhGreen, PhBlinkOn, PhBlinkOff, PhWalk};
    regs  = '{RegRedTicks, RegYellowTicks, RegGreenTicks, RegBlinkHalf,
              RegBlinkHalf, RegWalkTicks};
    drain_lamps();
    for (int k = 0; k < 6; k++) write_reg(regs[k], 16'd1);
    write_reg(RegBlinkRep, 16'hFFFF);
    for (int k = 0; k < 6; k++) begin
      run_until_phase(stops[k]);
      drain_lamps();
      write_reg(regs[k], 16'hFFFF);
      repeat (10) send_tick(1'($urandom_range(0, 1)));
      drain_lamps();
      write_reg(regs[k], 16'd1);
    end
    run_until_phase(PhWait);
    run_until_phase(PhRed);
  endtask

  task automatic test_backpressure();
    drain_lamps();
    write_reg(RegRedTicks, 16'd2);
    write_reg(RegGreenTicks, 16'd3);
    write_reg(RegBlinkRep, 16'd3);
    write_reg(RegWalkTicks, 16'd2);
    src_gaps        = 1'b0;
    snk_gaps        = 1'b0;
    hold_off_cycles = 40;
    repeat (30) send_tick(1'($urandom_range(0, 1)));
    drain_lamps();
    src_gaps = 1'b1;
    snk_gaps = 1'b1;
    repeat (20) send_tick(1'($urandom_range(0, 1)));
  endtask

  task automatic test_random_crossings();
    logic [CfgIdxBits-1:0]  idx;
    logic [CfgDataBits-1:0] val;
    logic                   btn;
    bit                     noisy;
    int unsigned            len;
    while (ticks_sent < TotalTicks) begin
      drain_lamps();
      for (int k = 0; k < 8; k++) begin
        if ($urandom_range(0, 2) == 0) begin
          idx = k[CfgIdxBits-1:0];
          case ($urandom_range(0, 15))
            0: val = '0;
            13, 14: val = CfgDataBits'($urandom_range(7, 40));
            15: val = CfgDataBits'($urandom_range(41, 16'hFFFF));
            default: val = CfgDataBits'($urandom_range(1, 6));
          endcase
          if (idx == RegBlinkRep) val = CfgDataBits'($urandom_range(0, 16'hFFFF));
          write_reg(idx, val);
        end
      end
      src_gaps = $urandom_range(0, 3) != 0;
      snk_gaps = $urandom_range(0, 3) != 0;
      noisy    = $urandom_range(0, 7) == 0;
      len      = $urandom_range(20, 80);
      repeat (len) begin
        if (noisy) begin
          btn = 1'($urandom_range(0, 1));
        end else begin
          case (phase_now)
            PhRed, PhYellow, PhGreen: btn = $urandom_range(0, 9) == 0;
            PhWait: btn = $urandom_range(0, 3) != 0;
            default: btn = 1'($urandom_range(0, 1));
          endcase
        end
        send_tick(btn);
      end
    end
  endtask

  initial begin : lamp_sink
    int unsigned gap;
    lamp_ch.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      gap = snk_gaps ? $urandom_range(0, 6) : 0;
      if (hold_off_cycles != 0) begin
        gap             = hold_off_cycles;
        hold_off_cycles = 0;
      end
      if (gap != 0) begin
        lamp_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      lamp_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!lamp_ch.valid) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin : lamp_check
    lamp_t want;
    lamp_t got;
    if (rst_ni && lamp_ch.valid && lamp_ch.ready) begin
      got.red     = lamp_ch.red_on;
      got.yellow  = lamp_ch.yellow_on;
      got.green   = lamp_ch.green_on;
      got.waiting = lamp_ch.request_waiting;
      got.phase   = phase_e'(lamp_ch.phase_code);
      if (pending_lamps.size() == 0) begin
        lamp_mismatches++;
        if (lamp_mismatches <= 10)
          $display("unexpected lamp transfer at %0t: phase %0d", $realtime, got.phase);
      end else begin
        want = pending_lamps.pop_front();
        if (got.red !== want.red || got.yellow !== want.yellow ||
            got.green !== want.green || got.waiting !== want.waiting ||
            got.phase !== want.phase) begin
          lamp_mismatches++;
          if (lamp_mismatches <= 10)
            $display("lamp mismatch at %0t: expected r%0b y%0b g%0b w%0b ph%0d, got r%0b y%0b g%0b w%0b ph%0d",
                     $realtime, want.red, want.yellow, want.green, want.waiting, want.phase,
                     got.red, got.yellow, got.green, got.waiting, got.phase);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (tick_ch.valid && tick_ch.ready) || (lamp_ch.valid && lamp_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == StallLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst_ni              <= 1'b0;
    cfg_we_i            <= 1'b0;
    cfg_idx_i           <= '0;
    cfg_data_i          <= '0;
    tick_ch.valid       <= 1'b0;
    tick_ch.button_down <= 1'b0;
    reset_lamp_model();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_state();
    test_zero_settings();
    test_full_scale();
    test_backpressure();
    test_random_crossings();
    drain_lamps();
    repeat (4) @(posedge clk_i);
    if (lamp_mismatches == 0 && pending_lamps.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
